FILE: hdl/montgomery_modular_arithmetic_unit_assert.svh
// Assertion macros used by the checker module.
`ifndef MONTGOMERY_MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MONTGOMERY_MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// ante true at an edge -> cons true at the same edge
`define MMAU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante true at an edge -> cons true at the next edge
`define MMAU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/mmau_pkg.sv
`default_nettype none
package mmau_pkg;

  localparam int WORD_BITS = 32;
  localparam int EXP_BITS  = 64;

  localparam int MOD_W     = 30;
  localparam int OPND_W    = 31;
  localparam int PLAIN_W   = 64;
  localparam int EXP_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(PLAIN_W);

  localparam logic [EXP_W-1:0] EXP_MASK = {EXP_W{1'b1}} >> (EXP_W - EXP_BITS);

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [2*WORD_BITS-1:0] dword_t;

  typedef enum logic [3:0] {
    OP_FROM_PLAIN = 4'd0,
    OP_TO_PLAIN   = 4'd1,
    OP_ADD        = 4'd2,
    OP_SUB        = 4'd3,
    OP_MUL        = 4'd4,
    OP_DIV        = 4'd5,
    OP_POWER      = 4'd6,
    OP_INVERSE    = 4'd7,
    OP_NEGATE     = 4'd8,
    OP_EQUAL      = 4'd9
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_NMI     = 2'd1,
    CFG_R2      = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALU,
    ST_MOD,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_PSTEP
  } state_t;

  typedef enum logic [2:0] {
    PH_FROM,
    PH_TOPLAIN,
    PH_EQ_A,
    PH_EQ_B,
    PH_MUL,
    PH_ONE,
    PH_ACC,
    PH_SQ
  } phase_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [OPND_W-1:0]  operand_a;
    logic [OPND_W-1:0]  operand_b;
    logic [PLAIN_W-1:0] plain_value;
    logic [EXP_W-1:0]   exponent;
  } cmd_t;

  typedef struct packed {
    logic [OPND_W-1:0] result_value;
    logic              is_equal;
  } result_t;

  typedef struct packed {
    logic [MOD_W-1:0]     modulus;
    logic [WORD_BITS-1:0] neg_mod_inverse;
    logic [MOD_W-1:0]     r_squared_mod;
  } cfg_t;

  typedef struct packed {
    logic    fin;
    result_t res;
  } core_status_t;

endpackage
`default_nettype wire

FILE: hdl/mmau_mul.sv
`default_nettype none
// Shared 32x32 multiplier, product registered.
module mmau_mul import mmau_pkg::*; (
  input  wire logic  clk,
  input  wire word_t x,
  input  wire word_t y,
  output dword_t     prod
);

  always_ff @(posedge clk) begin
    prod <= dword_t'(x) * dword_t'(y);
  end

endmodule
`default_nettype wire

FILE: hdl/mmau_core.sv
`default_nettype none
// Sequencer and datapath around the shared multiplier.
module mmau_core import mmau_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   go,
  input  wire cmd_t   cmd,
  input  wire cfg_t   cfg,
  output logic        busy,
  output core_status_t status
);

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [3:0]         op, op_next;
  logic [OPND_W-1:0]  a, a_next;
  logic [OPND_W-1:0]  b, b_next;
  logic [PLAIN_W-1:0] pv, pv_next;
  logic [EXP_W-1:0]   e, e_next;
  logic [MOD_W-1:0]   rem, rem_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  word_t              x, x_next;
  word_t              y, y_next;
  word_t              acc, acc_next;
  word_t              sq, sq_next;
  word_t              t1, t1_next;
  dword_t             p, p_next;

  word_t  mul_x, mul_y;
  dword_t prod;
  dword_t sum;
  word_t  mres;
  word_t  mfix;
  word_t  m_w;
  word_t  two_m;
  word_t  one_x;
  word_t  inv_e;
  word_t  alu_t;
  logic [MOD_W:0] sh;

  function automatic word_t leave_fix(input word_t t, input word_t m);
    leave_fix = (t >= m) ? t - m : t;
  endfunction

  mmau_mul u_mul (
    .clk  (clk),
    .x    (mul_x),
    .y    (mul_y),
    .prod (prod)
  );

  assign m_w   = word_t'(cfg.modulus);
  assign two_m = word_t'({cfg.modulus, 1'b0});
  // Montgomery one: (1 mod m) + m, then times R^2 and reduce
  assign one_x = (cfg.modulus > MOD_W'(1)) ? m_w + word_t'(1) : m_w;
  assign inv_e = m_w - word_t'(2);
  assign sum   = p + prod;
  assign mres  = sum[2*WORD_BITS-1:WORD_BITS];
  // plain residue of the REDC output
  assign mfix  = leave_fix(mres, m_w);
  assign busy  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_FROM;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    op  <= op_next;
    a   <= a_next;
    b   <= b_next;
    pv  <= pv_next;
    e   <= e_next;
    rem <= rem_next;
    cnt <= cnt_next;
    x   <= x_next;
    y   <= y_next;
    acc <= acc_next;
    sq  <= sq_next;
    t1  <= t1_next;
    p   <= p_next;
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    op_next    = op;
    a_next     = a;
    b_next     = b;
    pv_next    = pv;
    e_next     = e;
    rem_next   = rem;
    cnt_next   = cnt;
    x_next     = x;
    y_next     = y;
    acc_next   = acc;
    sq_next    = sq;
    t1_next    = t1;
    p_next     = p;
    mul_x      = x;
    mul_y      = y;
    alu_t      = '0;
    sh         = '0;
    status     = '0;

    unique case (state)
      ST_IDLE: begin
        if (go) begin
          op_next  = cmd.opcode;
          a_next   = cmd.operand_a;
          b_next   = cmd.operand_b;
          pv_next  = cmd.plain_value;
          rem_next = '0;
          cnt_next = '0;
          unique case (op_t'(cmd.opcode)) inside
            OP_FROM_PLAIN: begin
              state_next = ST_MOD;
            end
            OP_TO_PLAIN: begin
              x_next     = word_t'(cmd.operand_a);
              y_next     = word_t'(1);
              phase_next = PH_TOPLAIN;
              state_next = ST_M1;
            end
            OP_EQUAL: begin
              x_next     = word_t'(cmd.operand_a);
              y_next     = word_t'(1);
              phase_next = PH_EQ_A;
              state_next = ST_M1;
            end
            OP_MUL: begin
              x_next     = word_t'(cmd.operand_a);
              y_next     = word_t'(cmd.operand_b);
              phase_next = PH_MUL;
              state_next = ST_M1;
            end
            OP_POWER, OP_INVERSE, OP_DIV: begin
              if (op_t'(cmd.opcode) == OP_POWER) begin
                e_next = cmd.exponent & EXP_MASK;
              end else begin
                e_next = EXP_W'(inv_e);
              end
              sq_next    = (op_t'(cmd.opcode) == OP_DIV) ? word_t'(cmd.operand_b)
                                                         : word_t'(cmd.operand_a);
              x_next     = one_x;
              y_next     = word_t'(cfg.r_squared_mod);
              phase_next = PH_ONE;
              state_next = ST_M1;
            end
            default: begin
              state_next = ST_ALU;
            end
          endcase
        end
      end

      ST_ALU: begin
        case (op_t'(op))
          OP_ADD: alu_t = word_t'(a) + word_t'(b) - two_m;
          OP_SUB: alu_t = word_t'(a) - word_t'(b);
          OP_NEGATE: alu_t = word_t'(0) - word_t'(a);
          default: alu_t = '0;
        endcase
        if (alu_t[WORD_BITS-1]) begin
          alu_t = alu_t + two_m;
        end
        status.fin              = 1'b1;
        status.res.result_value = alu_t[OPND_W-1:0];
        state_next              = ST_IDLE;
      end

      // restoring remainder, one dividend bit a cycle
      ST_MOD: begin
        sh = {rem, pv[PLAIN_W-1]};
        if (sh >= {1'b0, cfg.modulus}) begin
          sh = sh - {1'b0, cfg.modulus};
        end
        rem_next = sh[MOD_W-1:0];
        pv_next  = pv << 1;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(PLAIN_W - 1)) begin
          x_next     = ((cfg.modulus == '0) ? word_t'(0) : word_t'(sh[MOD_W-1:0])) + m_w;
          y_next     = word_t'(cfg.r_squared_mod);
          phase_next = PH_FROM;
          state_next = ST_M1;
        end
      end

      // REDC: p = x*y, q = p_lo*nmi, result = (p + q*m) >> 32
      ST_M1: begin
        state_next = ST_M2;
      end

      ST_M2: begin
        mul_x      = prod[WORD_BITS-1:0];
        mul_y      = cfg.neg_mod_inverse;
        p_next     = prod;
        state_next = ST_M3;
      end

      ST_M3: begin
        mul_x      = prod[WORD_BITS-1:0];
        mul_y      = m_w;
        state_next = ST_M4;
      end

      ST_M4: begin
        case (phase) inside
          PH_FROM, PH_MUL: begin
            status.fin              = 1'b1;
            status.res.result_value = mres[OPND_W-1:0];
            state_next              = ST_IDLE;
          end
          PH_TOPLAIN: begin
            status.fin              = 1'b1;
            status.res.result_value = mfix[OPND_W-1:0];
            state_next              = ST_IDLE;
          end
          PH_EQ_A: begin
            t1_next    = mfix;
            x_next     = word_t'(b);
            y_next     = word_t'(1);
            phase_next = PH_EQ_B;
            state_next = ST_M1;
          end
          PH_EQ_B: begin
            status.fin          = 1'b1;
            status.res.is_equal = (mfix == t1);
            state_next          = ST_IDLE;
          end
          PH_ONE: begin
            acc_next   = mres;
            state_next = ST_PSTEP;
          end
          PH_ACC: begin
            acc_next = mres;
            if (e[EXP_W-1:1] == '0) begin
              // last exponent bit: the trailing square is not needed
              if (op_t'(op) == OP_DIV) begin
                x_next     = word_t'(a);
                y_next     = mres;
                phase_next = PH_MUL;
                state_next = ST_M1;
              end else begin
                status.fin              = 1'b1;
                status.res.result_value = mres[OPND_W-1:0];
                state_next              = ST_IDLE;
              end
            end else begin
              x_next     = sq;
              y_next     = sq;
              phase_next = PH_SQ;
              state_next = ST_M1;
            end
          end
          default: begin
            sq_next    = mres;
            e_next     = e >> 1;
            state_next = ST_PSTEP;
          end
        endcase
      end

      ST_PSTEP: begin
        if (e == '0) begin
          if (op_t'(op) == OP_DIV) begin
            x_next     = word_t'(a);
            y_next     = acc;
            phase_next = PH_MUL;
            state_next = ST_M1;
          end else begin
            status.fin              = 1'b1;
            status.res.result_value = acc[OPND_W-1:0];
            state_next              = ST_IDLE;
          end
        end else if (e[0]) begin
          x_next     = acc;
          y_next     = sq;
          phase_next = PH_ACC;
          state_next = ST_M1;
        end else begin
          x_next     = sq;
          y_next     = sq;
          phase_next = PH_SQ;
          state_next = ST_M1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/montgomery_modular_arithmetic_unit.sv
`default_nettype none
// Montgomery arithmetic unit, modulus odd and below 2^30, R = 2^32.
// Command channel: cmd is taken on a clock edge with start high and busy low;
// busy stays high until the result is produced. One command, one result.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall, so the transfer always completes in that cycle.
// Config: cfg_we/cfg_index/cfg_data write modulus (0), negated inverse of
// modulus mod 2^32 (1) and R^2 mod m (2); write only while not busy.
// Work from accept to done:
//   add, sub, negate, undefined opcodes : one ALU step
//   mul, to_plain                       : one REDC pass
//   equal                               : two REDC passes
//   from_plain                          : 64 remainder steps + REDC
//   power/inverse: a REDC pass for the Montgomery one, then LSB-first
//   square-and-multiply up to the top set bit of an exponent of at most
//   64 bits; divide adds a multiply by operand_a to the inverse of operand_b.
// Each REDC pass is three products through the single shared 32x32 multiplier
// (x*y, low word times the negated inverse, quotient times modulus) plus one
// 64-bit add; the multiplier is the pacing resource. One command at a time.
// Reset: sequencer idle, done low, modulus 1, negated inverse all ones,
// R^2 register zero.
module montgomery_modular_arithmetic_unit import mmau_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire cmd_t                 cmd,
  output logic                      busy,
  output logic                      done,
  output result_t                   result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_BITS-1:0] cfg_data
);

  cfg_t         cfg;
  core_status_t status;
  logic         core_busy;
  logic         go;

  // command transfer
  assign go   = start && !core_busy;
  assign busy = core_busy;

  // configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus         <= MOD_W'(1);
      cfg.neg_mod_inverse <= '1;
      cfg.r_squared_mod   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODULUS: cfg.modulus         <= cfg_data[MOD_W-1:0];
        CFG_NMI:     cfg.neg_mod_inverse <= cfg_data;
        CFG_R2:      cfg.r_squared_mod   <= cfg_data[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  mmau_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .cmd    (cmd),
    .cfg    (cfg),
    .busy   (core_busy),
    .status (status)
  );

  // result register: done strobes in the cycle after the core finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= status.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (status.fin) begin
      result <= status.res;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mmau_checker.sv
`default_nettype none
`include "montgomery_modular_arithmetic_unit_assert.svh"
module mmau_checker import mmau_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  // a result only appears once the sequencer has gone idle
  `MMAU_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  // an accepted command always occupies the unit
  `MMAU_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  // one strobe per command, never back to back
  `MMAU_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  // equal reports through the flag only
  `MMAU_ASSERT_IMP(a_eq_value_zero, clk, rst, done && result.is_equal, result.result_value == '0)

endmodule

bind montgomery_modular_arithmetic_unit mmau_checker u_mmau_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

FILE: verif/montgomery_result_checker.sv
module montgomery_result_checker import mmau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cmd_t                 cmd,
  input  logic                 busy,
  input  logic                 done,
  input  result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] opcode;
    result_t    res;
  } expected_t;

  // shadow copy of the register file
  logic [MOD_W-1:0]     mod_reg;
  logic [WORD_BITS-1:0] nmi_reg;
  logic [MOD_W-1:0]     r2_reg;

  expected_t awaited[$];

  function automatic word_t redc_step(dword_t y);
    word_t  q;
    dword_t sum;
    q   = y[WORD_BITS-1:0] * nmi_reg;
    sum = y + {32'd0, q} * {34'd0, mod_reg};
    return sum[2*WORD_BITS-1:WORD_BITS];
  endfunction

  function automatic word_t to_mont(dword_t y);
    dword_t rem;
    rem = (mod_reg == '0) ? '0 : y % {34'd0, mod_reg};
    return redc_step((rem + {34'd0, mod_reg}) * {34'd0, r2_reg});
  endfunction

  function automatic word_t from_mont(word_t x);
    word_t t;
    t = redc_step({32'd0, x});
    return (t >= {2'b0, mod_reg}) ? t - {2'b0, mod_reg} : t;
  endfunction

  function automatic word_t mont_product(word_t a, word_t b);
    return redc_step({32'd0, a} * {32'd0, b});
  endfunction

  function automatic word_t mont_difference(word_t a, word_t b);
    word_t t;
    t = a - b;
    if (t[WORD_BITS-1]) t = t + {1'b0, mod_reg, 1'b0};
    return t;
  endfunction

  // square-and-multiply, LSB first
  function automatic word_t mont_power(word_t base, dword_t e);
    word_t acc;
    word_t sq;
    acc = to_mont(64'd1);
    sq  = base;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) acc = mont_product(acc, sq);
      sq = mont_product(sq, sq);
    end
    return acc;
  endfunction

  function automatic word_t mont_inverse(word_t a);
    word_t e;
    e = {2'b0, mod_reg} - 32'd2;
    return mont_power(a, {32'd0, e});
  endfunction

  function automatic result_t modular_result(cmd_t c);
    word_t   a;
    word_t   b;
    word_t   r;
    word_t   t;
    logic    eq;
    result_t res;
    a  = {1'b0, c.operand_a};
    b  = {1'b0, c.operand_b};
    r  = '0;
    eq = 1'b0;
    case (c.opcode)
      OP_FROM_PLAIN: r = to_mont(c.plain_value);
      OP_TO_PLAIN:   r = from_mont(a);
      OP_ADD: begin
        t = a + b - {1'b0, mod_reg, 1'b0};
        if (t[WORD_BITS-1]) t = t + {1'b0, mod_reg, 1'b0};
        r = t;
      end
      OP_SUB:        r = mont_difference(a, b);
      OP_MUL:        r = mont_product(a, b);
      OP_DIV:        r = mont_product(a, mont_inverse(b));
      OP_POWER:      r = mont_power(a, c.exponent & EXP_MASK);
      OP_INVERSE:    r = mont_inverse(a);
      OP_NEGATE:     r = mont_difference('0, a);
      OP_EQUAL:      eq = (from_mont(a) == from_mont(b));
      default: ;
    endcase
    res.result_value = r[OPND_W-1:0];
    res.is_equal     = eq;
    return res;
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    expected_t want;
    if (rst) begin
      mod_reg = 30'd1;
      nmi_reg = '1;
      r2_reg  = '0;
      awaited.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODULUS: mod_reg = cfg_data[MOD_W-1:0];
          CFG_NMI:     nmi_reg = cfg_data;
          CFG_R2:      r2_reg  = cfg_data[MOD_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (awaited.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: result transfer with none expected, actual %h", $time, result);
        end else begin
          want = awaited.pop_front();
          if (result.result_value !== want.res.result_value) begin
            mismatches = mismatches + 1;
            $display("%0t: op %0d result_value expected %h, actual %h", $time,
                     want.opcode, want.res.result_value, result.result_value);
          end
          if (result.is_equal !== want.res.is_equal) begin
            mismatches = mismatches + 1;
            $display("%0t: op %0d is_equal expected %b, actual %b", $time,
                     want.opcode, want.res.is_equal, result.is_equal);
          end
        end
      end
      if (start && !busy) begin
        want.opcode = cmd.opcode;
        want.res    = modular_result(cmd);
        awaited.push_back(want);
      end
    end
    pending = awaited.size();
  end

endmodule

FILE: verif/tb_montgomery_modular_arithmetic_unit.sv
module tb_montgomery_modular_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mmau_pkg::*;

  // The slowest legal command is a power with an all-ones 64-bit exponent;
  // with idle gaps and 506 commands in all, this limit leaves ample margin.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned RAND_PER_PHASE = 60;
  localparam int unsigned NUM_PHASES = 8;

  localparam logic [MOD_W-1:0]     MAX_MOD = 30'h3FFF_FFFF;  // largest odd modulus
  localparam logic [OPND_W-1:0]    MAX_OPND = 31'h7FFF_FFFD; // 2*MAX_MOD - 1
  localparam logic [OPND_W-1:0]    MONT_ONE = 31'd4;         // R mod MAX_MOD
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;        // no register here

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  cmd_t                 cmd = '0;
  logic                 busy;
  logic                 done;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_BITS-1:0] cfg_data = '0;

  int                   mismatches;
  int                   pending;
  int unsigned          cycles = 0;
  bit                   idling = 1'b1;
  logic [MOD_W-1:0]     cur_mod = 30'd1;  // modulus currently loaded

  always #1 clk = ~clk;

  montgomery_modular_arithmetic_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  montgomery_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // -(m^-1) mod 2^32 by Newton iteration; 5 rounds cover 32 bits for odd m.
  function automatic logic [WORD_BITS-1:0] neg_inverse(logic [MOD_W-1:0] m);
    logic [WORD_BITS-1:0] inv;
    logic [WORD_BITS-1:0] mw;
    mw  = {2'b0, m};
    inv = mw;
    repeat (5) inv = inv * (32'd2 - mw * inv);
    return -inv;
  endfunction

  // 2^64 mod m
  function automatic logic [MOD_W-1:0] r_squared(logic [MOD_W-1:0] m);
    logic [64:0] pow;
    logic [64:0] rem;
    pow = 65'd1 << 64;
    rem = pow % {35'd0, m};
    return rem[MOD_W-1:0];
  endfunction

  function automatic cmd_t make_cmd(logic [3:0] op, logic [OPND_W-1:0] a,
                                    logic [OPND_W-1:0] b, logic [PLAIN_W-1:0] plain,
                                    logic [EXP_W-1:0] e);
    cmd_t c;
    c.opcode      = op;
    c.operand_a   = a;
    c.operand_b   = b;
    c.plain_value = plain;
    c.exponent    = e;
    return c;
  endfunction

  // Mostly weakly reduced operands in [0, 2m), some edges, some raw 31-bit noise.
  function automatic logic [OPND_W-1:0] random_operand(logic [MOD_W-1:0] m);
    logic [WORD_BITS-1:0] span;
    logic [WORD_BITS-1:0] raw;
    int                   kind;
    span = {1'b0, m, 1'b0};
    raw  = $urandom;
    kind = $urandom_range(0, 9);
    if (m == '0 || kind == 0) return raw[OPND_W-1:0];
    if (kind == 1) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return {1'b0, m};
        default: return span[OPND_W-1:0] - 31'd1;
      endcase
    end
    raw = $urandom_range(0, span - 1);
    return raw[OPND_W-1:0];
  endfunction

  function automatic logic [PLAIN_W-1:0] random_plain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return PLAIN_W'($urandom_range(0, 1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Exponents of varied length so power latency spreads out.
  function automatic logic [EXP_W-1:0] random_exponent();
    logic [EXP_W-1:0] e;
    e = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return EXP_W'($urandom_range(1, 16));
      3, 4, 5: return e >> $urandom_range(0, 63);
      default: return e;
    endcase
  endfunction

  function automatic cmd_t random_cmd(logic [MOD_W-1:0] m);
    cmd_t                 c;
    logic [WORD_BITS-1:0] a;
    if ($urandom_range(0, 19) == 0)
      c.opcode = 4'(OP_EQUAL + 1 + $urandom_range(0, 5));  // undefined opcodes
    else
      c.opcode = 4'($urandom_range(OP_FROM_PLAIN, OP_EQUAL));
    c.operand_a   = random_operand(m);
    c.operand_b   = random_operand(m);
    c.plain_value = random_plain();
    c.exponent    = random_exponent();
    // equal: half the time pair a with its other weakly reduced representative
    if (c.opcode == OP_EQUAL && m != '0 && $urandom_range(0, 1) == 1) begin
      a = {1'b0, c.operand_a};
      if (a < {2'b0, m})
        a = a + {2'b0, m};
      else if (a < {1'b0, m, 1'b0})
        a = a - {2'b0, m};
      c.operand_b = a[OPND_W-1:0];
    end
    return c;
  endfunction

  // One command transfer. Start stays high into the next command when there is
  // no gap, so it is never lowered and raised within one time step.
  task automatic issue(input cmd_t c);
    int gap;
    if (idling && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Block must be idle before registers change: every result back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Upper bits above the 30-bit fields carry junk; the block must mask them.
  task automatic load_regs(input logic [MOD_W-1:0] m, input logic [WORD_BITS-1:0] nmi,
                           input logic [MOD_W-1:0] r2, input bit poke_unmapped);
    logic [1:0] junk;
    junk = 2'($urandom);
    if (poke_unmapped) write_reg(CFG_UNMAPPED, $urandom);
    write_reg(CFG_MODULUS, {junk, m});
    write_reg(CFG_NMI, nmi);
    junk = 2'($urandom);
    write_reg(CFG_R2, {junk, r2});
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_mod  = m;
  endtask

  task automatic load_consistent(input logic [MOD_W-1:0] m);
    load_regs(m, neg_inverse(m), r_squared(m), 1'b0);
  endtask

  initial begin
    logic [MOD_W-1:0] m;
    logic [WORD_BITS-1:0] raw;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed: reset register values (modulus 1) ---
    issue(make_cmd(OP_FROM_PLAIN, '0, '0, '1, '0));
    issue(make_cmd(OP_POWER, 31'd1, '0, '0, 64'd5));
    issue(make_cmd(OP_EQUAL, '0, 31'd1, '0, '0));
    issue(make_cmd(OP_TO_PLAIN, '1, '0, '0, '0));

    // --- directed: largest modulus, field extremes, every opcode ---
    drain();
    load_consistent(MAX_MOD);
    issue(make_cmd(OP_FROM_PLAIN, '0, '0, '0, '0));
    issue(make_cmd(OP_FROM_PLAIN, '0, '0, '1, '0));
    issue(make_cmd(OP_TO_PLAIN, '0, '0, '0, '0));
    issue(make_cmd(OP_TO_PLAIN, MAX_OPND, '0, '0, '0));
    issue(make_cmd(OP_ADD, MAX_OPND, MAX_OPND, '0, '0));
    issue(make_cmd(OP_ADD, '0, '0, '0, '0));
    issue(make_cmd(OP_ADD, '1, '1, '0, '0));           // operands above 2m
    issue(make_cmd(OP_SUB, '0, MAX_OPND, '0, '0));
    issue(make_cmd(OP_SUB, MAX_OPND, '0, '0, '0));
    issue(make_cmd(OP_MUL, MAX_OPND, MAX_OPND, '0, '0));
    issue(make_cmd(OP_DIV, MAX_OPND, '0, '0, '0));     // divide by zero
    issue(make_cmd(OP_DIV, 31'd12345, MONT_ONE, '0, '0));
    issue(make_cmd(OP_POWER, MAX_OPND, '0, '0, '0));
    issue(make_cmd(OP_POWER, 31'd777, '0, '0, '1));
    issue(make_cmd(OP_INVERSE, MONT_ONE, '0, '0, '0));
    issue(make_cmd(OP_INVERSE, '0, '0, '0, '0));
    issue(make_cmd(OP_NEGATE, '0, '0, '0, '0));
    issue(make_cmd(OP_NEGATE, MAX_OPND, '0, '0, '0));
    issue(make_cmd(OP_EQUAL, 31'd5, 31'd5 + {1'b0, MAX_MOD}, '0, '0));
    issue(make_cmd(OP_EQUAL, 31'd5, 31'd6, '0, '0));
    issue(make_cmd(4'(OP_EQUAL + 1), 31'd9, 31'd9, '1, '1)); // undefined opcode
    issue(make_cmd('1, '1, '1, '1, '1));                 // undefined opcode

    // --- random phases, one register setting each ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      raw = $urandom;
      case (p)
        0: load_consistent(30'd3);
        1: load_consistent(MAX_MOD);
        2: load_consistent({raw[MOD_W-1:1], 1'b1});                  // large odd
        3: load_consistent({20'd0, raw[9:1], 1'b1});                 // small odd
        4: load_regs('0, '0, raw[MOD_W-1:0], 1'b1);                  // zero modulus
        5: load_regs(raw[MOD_W-1:0], $urandom, '1, 1'b0);            // inconsistent
        6: load_consistent(30'd1);
        default: begin
          m = MOD_W'($urandom);
          load_consistent({m[MOD_W-1:1], 1'b1});
        end
      endcase
      // final phase runs back to back
      if (p == NUM_PHASES - 1) idling = 1'b0;
      repeat (RAND_PER_PHASE) issue(random_cmd(cur_mod));
    end

    drain();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
